// ===== sv/salc_pkg.sv =====
// Shared widths, codes and controller command type for the set-associative LRU cache model.
`default_nettype none
package salc_pkg;

   localparam int ADDR_W      = 64;
   localparam int KIND_W      = 2;
   localparam int OUTCOME_W   = 2;
   localparam int WAY_OUT_W   = 3;
   localparam int COUNT_W     = 32;
   localparam int REQ_DATA_W  = 64;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 104;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 6;

   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;

   localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_FILL  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET   = 2'd2;

   localparam logic [COUNT_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic capture;
      logic read;
      logic commit;
   } ctrl_cmd_type;

endpackage
`default_nettype wire

// ===== sv/salc_ctrl.sv =====
// Sequencing state machine: accept, set read, update/commit, output valid.
`default_nettype none
module salc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output salc_pkg::ctrl_cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INDEX,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      out_free;
   logic      commit;
   logic      accept;

   always_comb begin
      out_free   = !rsp_tvalid_ff || rsp_tready;
      commit     = (state_ff == ST_UPDATE) && out_free;
      req_tready = (state_ff == ST_IDLE) || commit;
      accept     = req_tvalid && req_tready;

      cmd.capture = accept;
      cmd.read    = (state_ff == ST_INDEX);
      cmd.commit  = commit;

      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_INDEX;
         end
         ST_INDEX: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (commit) state_in = accept ? ST_INDEX : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      if (commit) rsp_tvalid_in = 1'b1;
      else if (rsp_tready) rsp_tvalid_in = 1'b0;
      else rsp_tvalid_in = rsp_tvalid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

endmodule
`default_nettype wire

// ===== sv/salc_datapath.sv =====
// Address split, set memories, hit/fill/victim selection, LRU update and running totals.
`default_nettype none
module salc_datapath #(
   parameter int SET_BITS_MAX = 6,
   parameter int WAYS         = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [salc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [salc_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  wire logic [salc_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  wire logic [salc_pkg::REQ_USER_W-1:0]       req_tuser,
   input  wire salc_pkg::ctrl_cmd_type                cmd,
   output logic [salc_pkg::RSP_DATA_W-1:0]            rsp_tdata
);

   localparam int SETS   = 1 << SET_BITS_MAX;
   localparam int SET_W  = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
   localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WAY_W  = RANK_W;
   localparam int SB_CAP = (SET_BITS_MAX > 7) ? 7 : SET_BITS_MAX;
   localparam int AW     = salc_pkg::ADDR_W;
   localparam int CW     = salc_pkg::COUNT_W;
   localparam logic [2:0]        SB_CAP_V = 3'(SB_CAP);
   localparam logic [4:0]        WAYS_V   = 5'(WAYS);
   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

   // configuration
   logic [2:0] cfg_set_bits_ff;
   logic [3:0] cfg_ways_ff;
   logic [5:0] cfg_offset_ff;

   // captured beat
   logic [salc_pkg::KIND_W-1:0] kind_ff;
   logic [AW-1:0]               addr_ff;

   // address split
   logic [2:0]       sb;
   logic [AW-1:0]    addr_shift;
   logic [SET_W-1:0] set_mask;
   logic [SET_W-1:0] set_idx;
   logic [6:0]       tag_shamt;
   logic [AW-1:0]    tag_val;
   logic [SET_W-1:0] set_ff;
   logic [AW-1:0]    tag_ff;

   // set storage
   logic [WAYS-1:0][AW-1:0]     tag_mem   [SETS];
   logic [WAYS-1:0][RANK_W-1:0] rank_mem  [SETS];
   logic [WAYS-1:0]             valid_mem [SETS];
   logic [SETS-1:0]             row_live_ff;

   logic [WAYS-1:0][AW-1:0]     rd_tags_ff;
   logic [WAYS-1:0][RANK_W-1:0] rd_rank_ff;
   logic [WAYS-1:0]             rd_valid_ff;
   logic                        rd_live_ff;

   // lookup and update
   logic [3:0]                  ways_lo;
   logic [4:0]                  ways_eff;
   logic [WAYS-1:0]             in_range;
   logic [WAYS-1:0]             valid_row;
   logic [WAYS-1:0][RANK_W-1:0] rank_row;
   logic                        hit;
   logic [WAY_W-1:0]            hit_way;
   logic                        free;
   logic [WAY_W-1:0]            free_way;
   logic [RANK_W-1:0]           best;
   logic [WAY_W-1:0]            vic_way;
   logic [WAY_W-1:0]            way_sel;
   logic                        was_valid;
   logic [RANK_W-1:0]           old_rank;
   logic [WAYS-1:0][RANK_W-1:0] new_rank;
   logic [WAYS-1:0]             new_valid;
   logic [WAYS-1:0][AW-1:0]     new_tags;
   logic [salc_pkg::OUTCOME_W-1:0] outcome;
   logic                        is_modify;

   // totals and result
   logic [CW-1:0] hit_total_ff, miss_total_ff, evict_total_ff;
   logic [1:0]    hit_inc;
   logic [CW:0]   hit_sum, miss_sum, evict_sum;
   logic [salc_pkg::OUTCOME_W-1:0] rsp_outcome_ff;
   logic                           rsp_extra_ff;
   logic [salc_pkg::WAY_OUT_W-1:0] rsp_way_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_set_bits_ff <= 3'd0;
         cfg_ways_ff     <= 4'd1;
         cfg_offset_ff   <= 6'd0;
      end else if (csr_we) begin
         case (csr_index)
            salc_pkg::CSR_SET_BITS: cfg_set_bits_ff <= csr_wdata[2:0];
            salc_pkg::CSR_WAYS:     cfg_ways_ff     <= csr_wdata[3:0];
            salc_pkg::CSR_OFFSET:   cfg_offset_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_tuser;
         addr_ff <= req_tdata;
      end
   end

   always_comb begin
      sb         = (cfg_set_bits_ff > SB_CAP_V) ? SB_CAP_V : cfg_set_bits_ff;
      addr_shift = addr_ff >> cfg_offset_ff;
      set_mask   = ~({SET_W{1'b1}} << sb);
      set_idx    = addr_shift[SET_W-1:0] & set_mask;
      tag_shamt  = {1'b0, cfg_offset_ff} + {4'b0, sb};
      tag_val    = tag_shamt[6] ? '0 : (addr_ff >> tag_shamt[5:0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         set_ff      <= set_idx;
         tag_ff      <= tag_val;
         rd_tags_ff  <= tag_mem[set_idx];
         rd_rank_ff  <= rank_mem[set_idx];
         rd_valid_ff <= valid_mem[set_idx];
      end
      if (cmd.commit) begin
         tag_mem[set_ff]   <= new_tags;
         rank_mem[set_ff]  <= new_rank;
         valid_mem[set_ff] <= new_valid;
      end
   end

   // a set never written reads as all lines invalid, rank zero
   always_ff @(posedge clock) begin
      if (reset) begin
         row_live_ff <= '0;
         rd_live_ff  <= 1'b0;
      end else begin
         if (cmd.read) rd_live_ff <= row_live_ff[set_idx];
         if (cmd.commit) row_live_ff[set_ff] <= 1'b1;
      end
   end

   always_comb begin
      ways_lo   = (cfg_ways_ff == 4'd0) ? 4'd1 : cfg_ways_ff;
      ways_eff  = ({1'b0, ways_lo} > WAYS_V) ? WAYS_V : {1'b0, ways_lo};
      valid_row = rd_live_ff ? rd_valid_ff : '0;
      rank_row  = rd_live_ff ? rd_rank_ff : '0;

      for (int v = 0; v < WAYS; v++) begin
         in_range[v] = 5'(v) < ways_eff;
      end

      hit      = 1'b0;
      hit_way  = '0;
      free     = 1'b0;
      free_way = '0;
      for (int v = WAYS - 1; v >= 0; v--) begin
         if (in_range[v] && valid_row[v] && (rd_tags_ff[v] == tag_ff)) begin
            hit     = 1'b1;
            hit_way = WAY_W'(v);
         end
         if (in_range[v] && !valid_row[v]) begin
            free     = 1'b1;
            free_way = WAY_W'(v);
         end
      end

      best    = '0;
      vic_way = '0;
      for (int v = 0; v < WAYS; v++) begin
         if (in_range[v] && (rank_row[v] > best)) begin
            best    = rank_row[v];
            vic_way = WAY_W'(v);
         end
      end

      if (hit) begin
         way_sel = hit_way;
         outcome = salc_pkg::OUTCOME_HIT;
      end else if (free) begin
         way_sel = free_way;
         outcome = salc_pkg::OUTCOME_FILL;
      end else begin
         way_sel = vic_way;
         outcome = salc_pkg::OUTCOME_EVICT;
      end

      was_valid = valid_row[way_sel];
      old_rank  = rank_row[way_sel];

      for (int v = 0; v < WAYS; v++) begin
         new_rank[v]  = rank_row[v];
         new_valid[v] = valid_row[v];
         new_tags[v]  = rd_tags_ff[v];
         if (WAY_W'(v) == way_sel) begin
            new_rank[v]  = '0;
            new_valid[v] = 1'b1;
            new_tags[v]  = tag_ff;
         end else if (in_range[v] && valid_row[v] &&
                      (!was_valid || (rank_row[v] < old_rank)) &&
                      (rank_row[v] != RANK_MAX)) begin
            new_rank[v] = rank_row[v] + 1'b1;
         end
      end

      is_modify = (kind_ff == salc_pkg::KIND_MODIFY);
      hit_inc   = {1'b0, hit} + {1'b0, is_modify};
      hit_sum   = {1'b0, hit_total_ff} + {{(CW-1){1'b0}}, hit_inc};
      miss_sum  = {1'b0, miss_total_ff} + {{CW{1'b0}}, !hit};
      evict_sum = {1'b0, evict_total_ff} + {{CW{1'b0}}, !hit && !free};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_total_ff   <= '0;
         miss_total_ff  <= '0;
         evict_total_ff <= '0;
      end else if (cmd.commit) begin
         hit_total_ff   <= hit_sum[CW] ? salc_pkg::TOTAL_MAX : hit_sum[CW-1:0];
         miss_total_ff  <= miss_sum[CW] ? salc_pkg::TOTAL_MAX : miss_sum[CW-1:0];
         evict_total_ff <= evict_sum[CW] ? salc_pkg::TOTAL_MAX : evict_sum[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_outcome_ff <= outcome;
         rsp_extra_ff   <= is_modify;
         rsp_way_ff     <= salc_pkg::WAY_OUT_W'(way_sel);
      end
   end

   assign rsp_tdata = {2'b00, evict_total_ff, miss_total_ff, hit_total_ff,
                       rsp_way_ff, rsp_extra_ff, rsp_outcome_ff};

endmodule
`default_nettype wire

// ===== sv/set_associative_lru_cache_sim_top.sv =====
// Top level of the set-associative cache tag and LRU replacement controller.
//
// Use: each req beat is one data access (address in req_tdata, access kind
// in req_tuser). Each access returns exactly one rsp beat with the outcome
// (hit, fill of a free way, or eviction), the way used, a flag for the second
// hit of a modify, and saturating running totals of hits, misses, evictions.
// The csr port sets the set index bits, ways in use and offset bits; write it
// only while no access is in flight.
// Order: the req beat is taken, its set row is read, then the tags are compared
// and the row is written back as the rsp beat is registered. Accesses do not
// overlap: a new access waits for the read-modify-write of the previous one.
// A new req beat is taken in the same cycle as the previous access commits.
// Stall: a result waits in the output register while rsp_tready is low; the
// next access is read from memory meanwhile and holds until the output frees.
// Reset: all lines invalid, LRU ranks and totals zero, registers at 0/1/0.
// Per-set live bits clear at reset, so no memory clearing pass is needed.
`default_nettype none
module set_associative_lru_cache_sim_top #(
   parameter int SET_BITS_MAX = 6,
   parameter int WAYS         = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [63:0] address
   input  wire logic [salc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] kind
   input  wire logic [salc_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [1:0] outcome, [2] extra_hit, [5:3] way_used, [37:6] hits_so_far,
   // [69:38] misses_so_far, [101:70] evictions_so_far, [103:102] zero
   output logic [salc_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   input  wire logic                               csr_we,
   input  wire logic [salc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [salc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   salc_pkg::ctrl_cmd_type cmd;

   salc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   salc_datapath #(
      .SET_BITS_MAX (SET_BITS_MAX),
      .WAYS         (WAYS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .rsp_tdata (rsp_tdata)
   );

endmodule
`default_nettype wire

// ===== sv/salc_checker.sv =====
// Port-level checker for the cache controller top, bound to it.
`default_nettype none
module salc_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [salc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_result_due: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##3 rsp_tvalid)
      else $error("no result three edges after accepted access");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second access taken while set read in progress");

   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == salc_pkg::OUTCOME_HIT) ||
                     (rsp_tdata[1:0] == salc_pkg::OUTCOME_FILL) ||
                     (rsp_tdata[1:0] == salc_pkg::OUTCOME_EVICT))
      else $error("undefined outcome code");

endmodule

bind set_associative_lru_cache_sim_top salc_checker u_salc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
